[rtl/base64_encoder_macros.svh]
// Assertion helpers for the base64 encoder.
// Both sample on clk and are switched off while arst_n is low.
`ifndef BASE64_ENCODER_MACROS_SVH
`define BASE64_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B64_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/b64enc_pkg.sv]
package b64enc_pkg;

	// ASCII code of the '=' pad
	localparam logic [6:0] PAD_CHAR = 7'd61;

	// Position within the current input triple
	typedef enum logic [1:0] {
		PH0 = 2'd0,
		PH1 = 2'd1,
		PH2 = 2'd2
	} phase_t;

	// Characters produced by one input byte, in output order
	typedef struct packed {
		logic [3:0][6:0] chars;
		logic [1:0]      last_idx;
		logic            fin;
	} job_t;

	typedef struct packed {
		phase_t     phase;
		logic [5:0] leftover;
	} front_status_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	// 6-bit group to its alphabet character (A-Z a-z 0-9 + /)
	function automatic logic [6:0] sym(input logic [5:0] idx);
		logic [6:0] wide;
		wide = {1'b0, idx};
		if (idx < 6'd26) begin
			sym = wide + 7'd65;
		end else if (idx < 6'd52) begin
			sym = wide + 7'd71;
		end else if (idx < 6'd62) begin
			sym = wide - 7'd4;
		end else if (idx == 6'd62) begin
			sym = 7'd43;
		end else begin
			sym = 7'd47;
		end
	endfunction

endpackage

[rtl/b64enc_front.sv]
// Front end: tracks the triple phase and turns each accepted byte into a job
// holding all of its characters, flush and pads included.
module b64enc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [7:0]                data_byte,
	input  logic                      final_byte,
	output b64enc_pkg::job_t          job,
	output b64enc_pkg::front_status_t status
);

	b64enc_pkg::phase_t phase_q;
	b64enc_pkg::phase_t ph_main;
	b64enc_pkg::phase_t phase_d;
	logic [5:0]         leftover_q;
	logic [5:0]         left_main;
	logic [5:0]         left_d;

	// Next phase and pending bits
	always_comb begin
		unique case (phase_q)
			b64enc_pkg::PH1: begin
				ph_main   = b64enc_pkg::PH2;
				left_main = {data_byte[3:0], 2'b00};
			end
			b64enc_pkg::PH2: begin
				ph_main   = b64enc_pkg::PH0;
				left_main = 6'd0;
			end
			default: begin
				ph_main   = b64enc_pkg::PH1;
				left_main = {data_byte[1:0], 4'b0000};
			end
		endcase
		phase_d = final_byte ? b64enc_pkg::PH0 : ph_main;
		left_d  = final_byte ? 6'd0 : left_main;
	end

	// Characters for this byte; unused slots default to pads
	always_comb begin
		job.chars = {4{b64enc_pkg::PAD_CHAR}};
		job.fin   = final_byte;
		unique case (phase_q)
			b64enc_pkg::PH1: begin
				job.chars[0] = b64enc_pkg::sym(leftover_q | {2'b00, data_byte[7:4]});
			end
			b64enc_pkg::PH2: begin
				job.chars[0] = b64enc_pkg::sym(leftover_q | {4'b0000, data_byte[7:6]});
			end
			default: begin
				job.chars[0] = b64enc_pkg::sym(data_byte[7:2]);
			end
		endcase
		if (phase_q == b64enc_pkg::PH2) begin
			job.chars[1] = b64enc_pkg::sym(data_byte[5:0]);
			job.last_idx = 2'd1;
		end else if (final_byte) begin
			// flush pending bits, then one or two pads
			job.chars[1] = b64enc_pkg::sym(left_main);
			job.last_idx = (ph_main == b64enc_pkg::PH1) ? 2'd3 : 2'd2;
		end else begin
			job.last_idx = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= b64enc_pkg::PH0;
			leftover_q <= 6'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			leftover_q <= left_d;
		end
	end

	assign status.phase    = phase_q;
	assign status.leftover = leftover_q;

endmodule

[rtl/b64enc_queue.sv]
// Short job queue between front and back end.
module b64enc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  b64enc_pkg::job_t          push_job,
	input  logic                      pop,
	output b64enc_pkg::job_t          head_job,
	output b64enc_pkg::queue_status_t status
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	b64enc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_job     = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CW'(DEPTH));

endmodule

[rtl/b64enc_back.sv]
// Back end: head job to output register, one character per cycle unless stalled.
module b64enc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  b64enc_pkg::job_t          head_job,
	input  b64enc_pkg::queue_status_t q_status,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [6:0]                out_char,
	output logic                      run_last,
	output logic                      message_end
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       take;
	logic       at_last;

	// Output register is free when empty or being taken
	assign load    = !valid_q || !out_stall;
	assign take    = load && !q_status.empty;
	assign at_last = (idx_q == head_job.last_idx);
	assign pop     = take && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= !q_status.empty;
			end
			if (take) begin
				idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Character payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_char    <= head_job.chars[idx_q];
			run_last    <= at_last;
			message_end <= at_last && head_job.fin;
		end
	end

	assign out_valid = valid_q;

endmodule

[rtl/base64_encoder.sv]
// Streaming base64 encoder (standard alphabet, '=' padded). One message byte
// enters per item with final_byte marking the last; each yields one character
// at the first and second byte of a triple, two at the third, and on the last
// byte the pending bits are flushed and pads added, up to four characters.
// run_last marks the last character of each byte, message_end the last of the
// message. Input is taken whenever the job queue (QUEUE_DEPTH entries) has
// room; the back end sends one character per cycle while out_stall is low, so
// a byte yields 1 to 4 characters (4 characters per 3 bytes in steady flow).
// The single output port sets the throughput. With the queue empty and the
// output free, the first character of a byte is written into the queue and
// then into the output register before it appears on the output.
`include "base64_encoder_macros.svh"

module base64_encoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] out_char,
	output logic       run_last,
	output logic       message_end
);

	b64enc_pkg::job_t          new_job;
	b64enc_pkg::job_t          head_job;
	b64enc_pkg::front_status_t f_status;
	b64enc_pkg::queue_status_t q_status;
	logic                      in_acc;
	logic                      pop;
	logic                      fin_acc;
	logic                      front_clear;

	assign in_stall = q_status.full;
	assign in_acc   = in_valid && !in_stall;

	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_acc),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (new_job),
		.status     (f_status)
	);

	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_acc),
		.push_job (new_job),
		.pop      (pop),
		.head_job (head_job),
		.status   (q_status)
	);

	b64enc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.q_status    (q_status),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

	// Last byte taken, and front state back at the start of a triple
	assign fin_acc     = in_acc && final_byte;
	assign front_clear = (f_status.phase == b64enc_pkg::PH0) && (f_status.leftover == 6'd0);

	`B64_ASSERT_SAME(a_end_is_run_last, out_valid && message_end, run_last, "end without run_last")
	`B64_ASSERT_SAME(a_no_pop_empty, pop, !q_status.empty, "job popped from empty queue")
	`B64_ASSERT_NEXT(a_final_resets, fin_acc, front_clear, "state not cleared after last byte")

endmodule
